// ===== src/tdd_pkg.sv =====
// Shared constants, types and codes of the trail diffuse/decay block.
package tdd_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int VALUE_BITS = 24;

  localparam int GEO_BITS    = 9;   // width_in_use / height_in_use field
  localparam int WEIGHT_BITS = 16;  // Q0.16 weights
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);  // runs into drain rows
  localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
  localparam int HGT_BITS = $clog2(MAX_HEIGHT + 1);
  localparam int SUM_BITS = VALUE_BITS + 4;           // ten terms at most
  localparam int WINDOW_CELLS = 9;

  localparam logic [WEIGHT_BITS-1:0] SPREAD_RESET = 16'd6554;
  localparam logic [WEIGHT_BITS-1:0] DECAY_RESET  = 16'd58982;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SPREAD = 2'd2,
    CFG_DECAY  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_MUL1,
    ST_MUL2
  } state_t;

  typedef struct packed {
    logic accept;    // capture input, read line stores
    logic load;      // shift window, write line stores, step position
    logic sum;       // window sum, frame restart on last cell
    logic mul1;      // spread scaling
    logic out_load;  // decay scaling into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;      // current transaction produces a result
    logic out_full;  // output register cannot take a new result
  } ctrl_sts_t;

endpackage

// ===== src/tdd_if.sv =====
// Channel interfaces: input cells, result cells, configuration writes.
interface tdd_in_if import tdd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] trail_value;
  logic                  flush;
  modport source (output valid, output trail_value, output flush, input ready);
  modport sink   (input valid, input trail_value, input flush, output ready);
endinterface

interface tdd_out_if import tdd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] new_value;
  logic                  last_of_frame;
  modport source (output valid, output new_value, output last_of_frame, input ready);
  modport sink   (input valid, input new_value, input last_of_frame, output ready);
endinterface

interface tdd_cfg_if import tdd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  reg_index;
  logic [CFG_DATA_BITS-1:0] wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== src/tdd_ctrl.sv =====
// Sequencer for one transaction: accept, window load, sum and, when it emits a result, two scalings.
module tdd_ctrl import tdd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = sts.emit ? ST_MUL1 : ST_IDLE;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/tdd_datapath.sv =====
// Line stores, 3x3 window, position counters, scaling and output register.
module tdd_datapath import tdd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_cmd_t                cmd,
  output ctrl_sts_t                sts,
  input  logic [VALUE_BITS-1:0]    trail_value,
  input  logic                     flush,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VALUE_BITS-1:0]    new_value,
  output logic                     last_of_frame,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PROD1_BITS = SUM_BITS + WEIGHT_BITS;
  localparam int PROD2_BITS = VALUE_BITS + WEIGHT_BITS;

  // configuration
  logic [WID_BITS-1:0]    width_r;
  logic [HGT_BITS-1:0]    height_r;
  logic [WEIGHT_BITS-1:0] spread_r, decay_r;
  logic [GEO_BITS-1:0]    geo_val;
  logic [WID_BITS-1:0]    width_nxt;
  logic [HGT_BITS-1:0]    height_nxt;
  logic                   geo_write;

  // position and window
  logic [COL_BITS-1:0]   col_r;
  logic [ROW_BITS-1:0]   row_r;
  logic [VALUE_BITS-1:0] win_r [WINDOW_CELLS];
  logic [VALUE_BITS-1:0] v_r;
  logic [VALUE_BITS-1:0] upper_rd_r, middle_rd_r;
  logic [VALUE_BITS-1:0] upper_mem  [MAX_WIDTH];
  logic [VALUE_BITS-1:0] middle_mem [MAX_WIDTH];

  // per-cell decode
  logic                  c_zero, emit, top_ok, bot_ok, left_ok, right_ok, wrap, last;
  logic [ROW_BITS-1:0]   qr;
  logic [WID_BITS-1:0]   qc, c_ext;
  logic [WINDOW_CELLS-1:0] mask_nxt, mask_r;
  logic                  emit_r, last_r;

  // arithmetic
  logic [SUM_BITS-1:0]   sum_nxt, sum_r;
  logic [PROD1_BITS-1:0] prod1;
  logic [SUM_BITS-1:0]   scaled1;
  logic [VALUE_BITS-1:0] d_r;
  logic [PROD2_BITS-1:0] prod2;
  logic [VALUE_BITS-1:0] res;

  logic                  out_valid_r, out_last_r;
  logic [VALUE_BITS-1:0] out_value_r;

  // geometry clamp: zero acts as one, large values saturate
  assign geo_val   = cfg_data[GEO_BITS-1:0];
  assign geo_write = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

  always_comb begin
    if (geo_val == '0) begin
      width_nxt  = WID_BITS'(1);
      height_nxt = HGT_BITS'(1);
    end else begin
      width_nxt  = (32'(geo_val) > MAX_WIDTH)  ? WID_BITS'(MAX_WIDTH)  : WID_BITS'(geo_val);
      height_nxt = (32'(geo_val) > MAX_HEIGHT) ? HGT_BITS'(MAX_HEIGHT) : HGT_BITS'(geo_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_BITS'(MAX_WIDTH);
      height_r <= HGT_BITS'(MAX_HEIGHT);
      spread_r <= SPREAD_RESET;
      decay_r  <= DECAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= width_nxt;
        CFG_HEIGHT: height_r <= height_nxt;
        CFG_SPREAD: spread_r <= cfg_data[WEIGHT_BITS-1:0];
        CFG_DECAY:  decay_r  <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // output cell position relative to the input position
  always_comb begin
    c_ext    = WID_BITS'(col_r);
    c_zero   = (col_r == '0);
    emit     = (row_r >= ROW_BITS'(2)) || (row_r == ROW_BITS'(1) && !c_zero);
    qr       = c_zero ? row_r - ROW_BITS'(2) : row_r - ROW_BITS'(1);
    qc       = c_zero ? width_r - WID_BITS'(1) : c_ext - WID_BITS'(1);
    top_ok   = (qr != '0);
    bot_ok   = ((ROW_BITS+1)'(qr) + (ROW_BITS+1)'(1)) < (ROW_BITS+1)'(height_r);
    left_ok  = (qc != '0);
    right_ok = ((WID_BITS+1)'(qc) + (WID_BITS+1)'(1)) < (WID_BITS+1)'(width_r);
    wrap     = ((WID_BITS+1)'(c_ext) + (WID_BITS+1)'(1)) >= (WID_BITS+1)'(width_r);
    last     = emit && !bot_ok && !right_ok;
    mask_nxt[0] = top_ok && left_ok;
    mask_nxt[1] = top_ok;
    mask_nxt[2] = top_ok && right_ok;
    mask_nxt[3] = left_ok;
    mask_nxt[4] = 1'b1;
    mask_nxt[5] = right_ok;
    mask_nxt[6] = bot_ok && left_ok;
    mask_nxt[7] = bot_ok;
    mask_nxt[8] = bot_ok && right_ok;
  end

  // line stores: read at accept, write back on window load
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      upper_rd_r  <= upper_mem[col_r];
      middle_rd_r <= middle_mem[col_r];
    end
    if (cmd.load) begin
      upper_mem[col_r]  <= middle_rd_r;
      middle_mem[col_r] <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v_r <= (flush || (32'(row_r) >= 32'(height_r))) ? '0 : trail_value;
    end
    if (cmd.load) begin
      mask_r <= mask_nxt;
    end
    if (cmd.sum) begin
      sum_r <= sum_nxt;
    end
    if (cmd.mul1) begin
      d_r <= (|scaled1[SUM_BITS-1:VALUE_BITS]) ? '1 : scaled1[VALUE_BITS-1:0];
    end
  end

  // position counters and window
  always_ff @(posedge clk) begin
    if (!rst_n || geo_write || (cmd.sum && last_r)) begin
      col_r  <= '0;
      row_r  <= '0;
      for (int i = 0; i < WINDOW_CELLS; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        win_r[3*i]   <= win_r[3*i+1];
        win_r[3*i+1] <= win_r[3*i+2];
      end
      win_r[2] <= upper_rd_r;
      win_r[5] <= middle_rd_r;
      win_r[8] <= v_r;
      if (wrap) begin
        col_r <= '0;
        row_r <= row_r + ROW_BITS'(1);
      end else begin
        col_r <= col_r + COL_BITS'(1);
      end
    end
  end

  // per-transaction flags, held through a frame restart until the output load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      last_r <= 1'b0;
    end else if (cmd.load) begin
      emit_r <= emit;
      last_r <= last;
    end
  end

  // centre counted twice
  always_comb begin
    sum_nxt = SUM_BITS'(win_r[4]);
    for (int i = 0; i < WINDOW_CELLS; i++) begin
      if (mask_r[i]) begin
        sum_nxt = sum_nxt + SUM_BITS'(win_r[i]);
      end
    end
  end

  assign prod1   = PROD1_BITS'(sum_r) * PROD1_BITS'(spread_r);
  assign scaled1 = prod1[PROD1_BITS-1:WEIGHT_BITS];
  // d below 2^VALUE_BITS and decay below 1.0: no overflow here
  assign prod2   = PROD2_BITS'(d_r) * PROD2_BITS'(decay_r);
  assign res     = prod2[PROD2_BITS-1:WEIGHT_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= res;
      out_last_r  <= last_r;
    end
  end

  assign sts.emit     = emit_r;
  assign sts.out_full = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign new_value     = out_value_r;
  assign last_of_frame = out_last_r;

endmodule

// ===== src/trail_diffuse_decay.sv =====
// Top level: streaming 3x3 trail diffusion followed by decay.
//
//  channel   dir  payload                            transfer
//  in_ch     in   trail_value[23:0], flush           valid & ready
//  out_ch    out  new_value[23:0], last_of_frame     valid & ready
//  cfg_ch    in   reg_index[1:0], wr_data[15:0]      valid & ready (ready held high)
//
//  Steps: accept, window load and sum for a transaction with no result;
//  accept, load, sum, spread multiply and decay multiply into the output
//  register for a transaction with a result.
//  Reset: rst_n synchronous active low; geometry 256x256, weights to defaults,
//  frame position and window cleared. Line stores are not cleared.
//  Stalls: a full output register holds the sequencer in its last step;
//  in_ch.ready is high only while the sequencer is idle.
//  A width or height write restarts the frame.
module trail_diffuse_decay import tdd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tdd_in_if.sink    in_ch,
  tdd_out_if.source out_ch,
  tdd_cfg_if.sink   cfg_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  // configuration writes must only arrive while idle (the block does not enforce this), so always take them
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  tdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .trail_value   (in_ch.trail_value),
    .flush         (in_ch.flush),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .new_value     (out_ch.new_value),
    .last_of_frame (out_ch.last_of_frame),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.reg_index),
    .cfg_data      (cfg_ch.wr_data)
  );

endmodule
